### rtl/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

  localparam int FRAC_BITS_DEF   = 14;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int STEP_W  = 18;
  localparam int START_W = 14;
  localparam int SKIP_W  = 4;
  localparam int PRIME_W = 2;

  // results per input word, and the counter that tracks them
  localparam int MAX_OUT = 64;
  localparam int CNT_W   = $clog2(MAX_OUT);

  localparam logic [SKIP_W-1:0]  SKIP_MAX   = 4'd15;
  localparam logic [STEP_W-1:0]  STEP_RESET = 18'd16384;
  localparam logic [START_W-1:0] START_RESET = 14'd0;

  // configuration register indexes
  localparam logic REG_PHASE_STEP  = 1'b0;
  localparam logic REG_START_PHASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_ADD
  } lir_state_t;

  typedef struct packed {
    logic load_in;
    logic prime_shift;
    logic skip_shift;
    logic mul;
    logic emit;
    logic last;
  } lir_cmd_t;

  typedef struct packed {
    logic prime_done;
    logic skip_zero;
    logic carry_nz;
    logic out_free;
  } lir_stat_t;

endpackage

### rtl/lir_dp.sv
`timescale 1ns / 1ps

module lir_dp #(
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lir_pkg::lir_cmd_t                 cmd,
  output lir_pkg::lir_stat_t                stat,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              stream_start,
  input  logic [lir_pkg::STEP_W-1:0]        phase_step,
  input  logic [lir_pkg::START_W-1:0]       start_phase,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic                              last
);

  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W   = ((FRAC_BITS > lir_pkg::STEP_W) ? FRAC_BITS : lir_pkg::STEP_W) + 1;
  localparam int CARRY_W = SUM_W - FRAC_BITS;
  localparam int SAT_W   = CARRY_W + lir_pkg::SKIP_W;

  logic signed [SAMPLE_BITS-1:0]   older_sample;
  logic signed [SAMPLE_BITS-1:0]   newer_sample;
  logic signed [SAMPLE_BITS-1:0]   held_sample;
  logic [FRAC_BITS-1:0]            phase;
  logic [lir_pkg::SKIP_W-1:0]      skip_count;
  logic [lir_pkg::PRIME_W-1:0]     prime_count;
  logic signed [PROD_W-1:0]        prod;

  logic [FRAC_BITS-1:0]            start_ext;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [PROD_W-1:0]        quot;
  logic signed [SAMPLE_BITS-1:0]   interp;
  logic [SUM_W-1:0]                sum;
  logic [CARRY_W-1:0]              carry;
  logic [CARRY_W-1:0]              carry_m1;
  logic [lir_pkg::SKIP_W-1:0]      skip_sat;
  logic                            shift_pair;

  // start phase fitted to the fraction width
  always_comb begin
    start_ext = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (i < lir_pkg::START_W) begin
        start_ext[i] = start_phase[i];
      end
    end
  end

  assign diff   = DIFF_W'(newer_sample) - DIFF_W'(older_sample);
  assign quot   = prod >>> FRAC_BITS;
  assign interp = older_sample + $signed(quot[SAMPLE_BITS-1:0]);

  assign sum      = SUM_W'(phase) + SUM_W'(phase_step);
  assign carry    = sum[SUM_W-1:FRAC_BITS];
  assign carry_m1 = carry - CARRY_W'(1);
  assign skip_sat = (SAT_W'(carry_m1) > SAT_W'(lir_pkg::SKIP_MAX)) ?
                    lir_pkg::SKIP_MAX : lir_pkg::SKIP_W'(SAT_W'(carry_m1));

  assign shift_pair = cmd.prime_shift || cmd.skip_shift || (cmd.emit && cmd.last);

  assign stat.prime_done = prime_count[1];
  assign stat.skip_zero  = (skip_count == '0);
  assign stat.carry_nz   = (carry != '0);
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= '0;
      skip_count  <= '0;
      phase       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_in && stream_start) begin
        prime_count <= '0;
        skip_count  <= '0;
        phase       <= start_ext;
      end
      if (cmd.prime_shift) begin
        prime_count <= prime_count + lir_pkg::PRIME_W'(1);
      end
      if (cmd.skip_shift) begin
        skip_count <= skip_count - lir_pkg::SKIP_W'(1);
      end
      if (cmd.emit) begin
        phase <= sum[FRAC_BITS-1:0];
        if (stat.carry_nz) begin
          skip_count <= skip_sat;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      held_sample <= sample;
    end
    if (shift_pair) begin
      older_sample <= newer_sample;
      newer_sample <= held_sample;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, phase}));
    end
    if (cmd.emit) begin
      out_sample <= interp;
      last       <= cmd.last;
    end
  end

  a_prime_bound: assert property (@(posedge clk) disable iff (rst)
    prime_count != 2'd3)
    else $error("prime count ran past two");

  a_skip_primed: assert property (@(posedge clk) disable iff (rst)
    (skip_count != '0) |-> prime_count[1])
    else $error("skip pending while still priming");

  a_last_on_carry: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.last) |-> !stat.carry_nz)
    else $error("result emitted without last although phase carried");

endmodule

### rtl/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lir_pkg::lir_stat_t stat,
  output lir_pkg::lir_cmd_t  cmd
);

  lir_pkg::lir_state_t        state;
  lir_pkg::lir_state_t        state_next;
  logic [lir_pkg::CNT_W-1:0]  out_count;
  logic [lir_pkg::CNT_W-1:0]  out_count_next;
  logic                       final_out;

  assign final_out = stat.carry_nz ||
                     (out_count == lir_pkg::CNT_W'(lir_pkg::MAX_OUT - 1));

  always_comb begin
    state_next = state;
    case (state)
      lir_pkg::ST_IDLE: begin
        if (in_valid) state_next = lir_pkg::ST_DECIDE;
      end
      lir_pkg::ST_DECIDE: begin
        if (!stat.prime_done || !stat.skip_zero) state_next = lir_pkg::ST_IDLE;
        else state_next = lir_pkg::ST_MUL;
      end
      lir_pkg::ST_MUL: begin
        state_next = lir_pkg::ST_ADD;
      end
      lir_pkg::ST_ADD: begin
        if (stat.out_free) begin
          state_next = final_out ? lir_pkg::ST_IDLE : lir_pkg::ST_MUL;
        end
      end
      default: state_next = lir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    out_count_next = out_count;
    case (state)
      lir_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_in    = in_valid;
        out_count_next = '0;
      end
      lir_pkg::ST_DECIDE: begin
        cmd.prime_shift = !stat.prime_done;
        cmd.skip_shift  = stat.prime_done && !stat.skip_zero;
      end
      lir_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      lir_pkg::ST_ADD: begin
        cmd.emit = stat.out_free;
        cmd.last = final_out;
        if (stat.out_free) begin
          out_count_next = final_out ? '0 : out_count + lir_pkg::CNT_W'(1);
        end
      end
      default: begin
        out_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lir_pkg::ST_IDLE;
      out_count <= '0;
    end else begin
      state     <= state_next;
      out_count <= out_count_next;
    end
  end

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state == lir_pkg::ST_IDLE) |-> (out_count == '0))
    else $error("result count not cleared between words");

  a_add_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == lir_pkg::ST_ADD) |->
      ($past(state) == lir_pkg::ST_MUL || $past(state) == lir_pkg::ST_ADD))
    else $error("add step entered without a fresh product");

  a_emit_only_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.last) |=> (state == lir_pkg::ST_MUL))
    else $error("loop did not return to multiply after a non-final result");

endmodule

### rtl/linear_interp_resampler.sv
`timescale 1ns / 1ps

// Linear-interpolation sample-rate converter. Each input word carries one
// signed source sample; the block keeps the two most recent samples and a
// fractional phase between them, and for every output emits
// older + floor((newer - older) * phase / 2^FRAC_BITS), then advances the
// phase by phase_step (one input sample = 2^FRAC_BITS). Outputs between
// samples n and n+1 appear when sample n+2 arrives; the final result caused
// by an input word carries last. The first two words after reset or after a
// word with stream_start set only prime the pair, and stream_start also
// loads start_phase. A large step skips input words (up to 15); a step too
// small to carry within 64 results stops at 64 results for that word.
// Steps: an input word that yields no result is accepted and then decided;
// a word yielding results is also accepted and decided, then each result goes
// through one pass of the shared multiplier followed by the add into the
// output register, which waits while the output side stalls. in_stall is high
// whenever a word is being worked on. The output register lets the next word
// be accepted while the last result still waits. Write phase_step (index 0)
// and start_phase (index 1) only while the block is idle.
module linear_interp_resampler #(
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           stream_start,
  // result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_sample,
  output logic                           last,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [lir_pkg::STEP_W-1:0]     cfg_data
);

  logic [lir_pkg::STEP_W-1:0]  phase_step;
  logic [lir_pkg::START_W-1:0] start_phase;
  lir_pkg::lir_cmd_t           cmd;
  lir_pkg::lir_stat_t          stat;

  // Registers are always writable; the user keeps writes to idle periods.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= lir_pkg::STEP_RESET;
      start_phase <= lir_pkg::START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lir_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data;
        lir_pkg::REG_START_PHASE: start_phase <= cfg_data[lir_pkg::START_W-1:0];
        default: begin
          // hold both registers
        end
      endcase
    end
  end

  // Sequencer: accept, decide prime/skip/emit, then multiply/add per result.
  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Sample pair, phase, counts, the multiplier and the output register.
  lir_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .stream_start (stream_start),
    .phase_step   (phase_step),
    .start_phase  (start_phase),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_sample   (out_sample),
    .last         (last)
  );

endmodule

### bench/tb_linear_interp_resampler.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler;
  import lir_pkg::*;

  localparam int SW             = SAMPLE_BITS_DEF;
  localparam int FB             = FRAC_BITS_DEF;
  localparam int TOTAL_WORDS    = 480;
  // quiet time after the last result; leave a generous margin
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 last;
  } interp_out_t;

  logic clk = 1'b0;
  logic rst;

  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] sample;
  logic                 stream_start;

  logic                 out_valid;
  logic                 out_stall;
  logic signed [SW-1:0] out_sample;
  logic                 last;

  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [STEP_W-1:0]    cfg_data;

  // Predicted resampler state and register copies.
  logic signed [SW-1:0] pair_old    = '0;
  logic signed [SW-1:0] pair_new    = '0;
  logic [FB-1:0]        frac_pos    = '0;
  logic [SKIP_W-1:0]    skip_left   = '0;
  logic [PRIME_W-1:0]   primed      = '0;
  logic [STEP_W-1:0]    step_reg    = STEP_RESET;
  logic [START_W-1:0]   start_reg   = START_RESET;

  interp_out_t expected_outs[$];

  int words_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int errors          = 0;
  int most_per_word   = 0;

  // Idling controls; rx_idle_on and hold_left are shared with the receiver process.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int hold_left  = 0;

  linear_interp_resampler dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .stream_start (stream_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Gap length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 6) return {1'b0, {(SW-1){1'b1}}};
    if (r < 12) return {1'b1, {(SW-1){1'b0}}};
    if (r < 25) begin
      v = int'($urandom_range(0, 200)) - 100;
      return v[SW-1:0];
    end
    v = $urandom();
    return v[SW-1:0];
  endfunction

  // Step mix: mostly around unity, with slow, fast, extreme and sub-range steps.
  function automatic logic [STEP_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return STEP_W'($urandom_range(8192, 49152));
    if (r < 70) return STEP_W'($urandom_range(256, 2047));
    if (r < 85) return STEP_W'($urandom_range(65536, 262143));
    if (r < 90) return 18'd256;
    if (r < 95) return 18'd262143;
    return STEP_W'($urandom_range(0, 255));
  endfunction

  // Start phase with junk in the unused upper data bits, which must be dropped.
  function automatic logic [STEP_W-1:0] pick_start();
    int r;
    logic [START_W-1:0] ph;
    logic [STEP_W-START_W-1:0] junk;
    r = $urandom_range(0, 99);
    if (r < 15) ph = '0;
    else if (r < 30) ph = '1;
    else ph = START_W'($urandom_range(0, 16383));
    junk = (STEP_W-START_W)'($urandom_range(0, 15));
    return {junk, ph};
  endfunction

  // Advance the predicted state by one accepted word and queue its results.
  task automatic resample_word(input logic signed [SW-1:0] s, input logic restart);
    longint      prod;
    longint      interp;
    logic [STEP_W:0] sum;
    int          carry;
    int          n;
    bit          done;
    interp_out_t o;
    if (restart) begin
      primed    = '0;
      skip_left = '0;
      frac_pos  = start_reg[FB-1:0];
    end
    if (primed < 2) begin
      // priming word: fill the pair only
      pair_old = pair_new;
      pair_new = s;
      primed++;
      return;
    end
    if (skip_left != 0) begin
      skip_left--;
      pair_old = pair_new;
      pair_new = s;
      return;
    end
    n    = 0;
    done = 1'b0;
    while (!done) begin
      prod    = (longint'(pair_new) - longint'(pair_old)) * longint'(frac_pos);
      // arithmetic shift floors toward minus infinity
      interp  = longint'(pair_old) + (prod >>> FB);
      o.value = interp[SW-1:0];
      n++;
      sum      = frac_pos + step_reg;
      carry    = int'(sum >> FB);
      frac_pos = sum[FB-1:0];
      if (carry != 0) begin
        skip_left = (carry - 1 > int'(SKIP_MAX)) ? SKIP_MAX : SKIP_W'(carry - 1);
        done      = 1'b1;
      end else if (n == MAX_OUT) begin
        // step too small to carry: stop at the cap, no skip follows
        done = 1'b1;
      end
      o.last = done;
      expected_outs.push_back(o);
    end
    if (n > most_per_word) most_per_word = n;
    pair_old = pair_new;
    pair_new = s;
  endtask

  // Offer one word after an optional gap; return at the edge that takes it.
  task automatic send_word(input logic signed [SW-1:0] s, input logic restart,
                           input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample       <= s;
    stream_start <= restart;
    do @(posedge clk); while (in_stall);
    resample_word(s, restart);
    words_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the block go quiet.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [STEP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PHASE_STEP) step_reg = data;
    else start_reg = data[START_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // After reset, with no stream start: the first two words only prime the pair.
  task automatic test_reset_priming();
    send_word(24'sh7FFFFF, 1'b0, 0);
    send_word(24'sh800000, 1'b0, 0);
    send_word(24'sh7FFFFF, 1'b0, 0);
    send_word(24'sh800000, 1'b0, 1);
    send_word(24'sh000001, 1'b0, 0);
  endtask

  // Full-scale swings at the largest start phase: big products, floor on negatives.
  task automatic test_sample_extremes();
    wait_idle();
    write_reg(REG_START_PHASE, 18'd16383);
    write_reg(REG_PHASE_STEP, 18'd16383);
    send_word(24'sh800000, 1'b1, 0);
    send_word(24'sh7FFFFF, 1'b0, 0);
    send_word(24'sh800000, 1'b0, 0);
    send_word(24'sh7FFFFF, 1'b0, 0);
  endtask

  // Zero step freezes the phase; 255 from the top start phase carries at once; 256 carries on the cap.
  task automatic test_small_step();
    wait_idle();
    write_reg(REG_PHASE_STEP, 18'd0);
    send_word(24'sd5, 1'b1, 0);
    send_word(-24'sd7, 1'b0, 0);
    send_word(24'sd123, 1'b0, 0);
    wait_idle();
    write_reg(REG_PHASE_STEP, 18'd255);
    send_word(-24'sd3, 1'b1, 0);
    send_word(24'sd1000, 1'b0, 0);
    send_word(-24'sd2, 1'b0, 0);
    wait_idle();
    write_reg(REG_START_PHASE, 18'd0);
    write_reg(REG_PHASE_STEP, 18'd256);
    send_word(24'sh7FFFFF, 1'b1, 0);
    send_word(24'sh800000, 1'b0, 0);
    send_word(24'sd77, 1'b0, 0);
  endtask

  // Largest step from the top start phase: one result, then the skip count reaches its maximum of 15.
  task automatic test_large_step();
    wait_idle();
    write_reg(REG_START_PHASE, 18'd16383);
    write_reg(REG_PHASE_STEP, 18'd262143);
    send_word(24'sd100, 1'b1, 0);
    send_word(-24'sd100, 1'b0, 0);
    send_word(24'sd7, 1'b0, 0);
    send_word(24'sd8, 1'b0, 0);
    send_word(24'sd9, 1'b0, 0);
    send_word(24'sd10, 1'b0, 0);
  endtask

  // Stream start in mid-stream re-primes the pair and reloads the phase.
  task automatic test_stream_restart();
    wait_idle();
    write_reg(REG_START_PHASE, 18'd8192);
    write_reg(REG_PHASE_STEP, 18'd24576);
    send_word(24'sd1000, 1'b1, 0);
    send_word(24'sd3000, 1'b0, 0);
    send_word(-24'sd5000, 1'b0, 0);
    send_word(24'sd42, 1'b1, 0);
    send_word(-24'sd42, 1'b0, 0);
    send_word(24'sd999, 1'b0, 0);
  endtask

  // Hold the receiver off while words keep coming, then pause until drained.
  task automatic test_backpressure();
    int i;
    wait_idle();
    write_reg(REG_PHASE_STEP, 18'd16384);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left  = HOLD_CYCLES;
    for (i = 0; i < 30; i++) send_word(rand_sample(), i == 0, 0);
    wait_idle();
    rx_idle_on = 1'b1;
    for (i = 0; i < 10; i++) send_word(rand_sample(), 1'b0, 0);
  endtask

  // Well-formed streams with random content and settings, some stray restarts.
  task automatic test_random_streams();
    int len;
    int i;
    logic restart;
    while (words_sent < TOTAL_WORDS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) begin
        wait_idle();
        if ($urandom_range(0, 9) < 7) write_reg(REG_PHASE_STEP, pick_step());
        if ($urandom_range(0, 9) < 6) write_reg(REG_START_PHASE, pick_start());
      end
      // slow steps give up to the cap per word: keep those streams short
      len = (step_reg < 4096) ? $urandom_range(3, 8) : $urandom_range(4, 30);
      for (i = 0; i < len; i++) begin
        restart = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        send_word(rand_sample(), restart, tx_idle_on ? gap_len() : 0);
      end
    end
  endtask

  // Receiver: random stall bursts, or a long hold-off when one is requested.
  initial begin : receiver
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!rx_idle_on) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        out_stall  <= 1'b0;
        run_left   = $urandom_range(0, 12);
        stall_left = gap_len();
      end
    end
  end

  // Compare every result word taken with the oldest expectation.
  always @(posedge clk) begin
    interp_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outs.size() == 0) begin
        $display("%0t unexpected result: actual out_sample %0d last %0b",
                 $time, out_sample, last);
        errors++;
      end else begin
        want = expected_outs.pop_front();
        results_checked++;
        if (out_sample !== want.value) begin
          $display("%0t out_sample mismatch: expected %0d, actual %0d",
                   $time, want.value, out_sample);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t last mismatch: expected %0b, actual %0b",
                   $time, want.last, last);
          errors++;
        end
      end
    end
  end

  // Stop the run if no handshake of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, expected_outs.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    stream_start = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_PHASE_STEP;
    cfg_data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_priming();
    test_sample_extremes();
    test_small_step();
    test_large_step();
    test_stream_restart();
    test_backpressure();
    test_random_streams();
    wait_idle();

    $display("Sent %0d input words, checked %0d results, %0d register writes",
             words_sent, results_checked, reg_writes);
    $display("Most results from one word: %0d; %0d mismatches",
             most_per_word, errors);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
